@@ sv/mbrs_pkg.sv @@
// Shared types, register indexes and defaults for the bitmap row run splitter.
`timescale 1ns / 1ps

package mbrs_pkg;

  // Default sizing
  localparam int MAX_ROW_WIDTH_DEF = 4096;
  localparam int COLOR_BITS_DEF    = 32;
  localparam int COORD_BITS_DEF    = 16;

  // Descriptor queue depth between front and back
  localparam int QUEUE_DEPTH = 2;

  // Bit position of the leftmost pixel in a byte
  localparam logic [2:0] BIT_MSB = 3'd7;

  // Pixels in a whole byte
  localparam logic [3:0] BYTE_PIX = 4'd8;

  // Register map, byte address = 4 * index
  typedef enum logic [2:0] {
    REG_ORIGIN_X     = 3'd0,
    REG_ORIGIN_Y     = 3'd1,
    REG_ROW_WIDTH    = 3'd2,
    REG_ROW_COUNT    = 3'd3,
    REG_FIRST_OFFSET = 3'd4,
    REG_ZERO_COLOR   = 3'd5,
    REG_ONE_COLOR    = 3'd6,
    REG_TRANSP_MASK  = 3'd7
  } reg_idx_t;

  // Fixed-width configuration seen by front and back
  typedef struct packed {
    logic [15:0] origin_x;
    logic [15:0] origin_y;
    logic [12:0] row_width;
    logic [15:0] row_count;
    logic [2:0]  first_bit_offset;
    logic [1:0]  transparent_mask;
  } cfg_t;

  // Work for one accepted byte, handed from front to back
  typedef struct packed {
    logic [7:0] data_byte;
    logic [2:0] start_bit;   // bit of the first pixel used
    logic [3:0] npix;        // pixels used from this byte, 1..8
    logic       row_start;
    logic       load_y;      // first row of the area
    logic       row_end;
  } desc_t;

endpackage

@@ sv/mbrs_front.sv @@
// Front end: accepts bytes, tracks row position and classifies each byte.
`timescale 1ns / 1ps

module mbrs_front
  import mbrs_pkg::*;
#(
  parameter int MAX_ROW_WIDTH = MAX_ROW_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       q_full,
  output logic       q_push,
  output desc_t      q_desc
);

  localparam int PW = $clog2(MAX_ROW_WIDTH + 1);

  logic [PW-1:0] pix_idx;
  logic [PW-1:0] pix_idx_next;
  logic [15:0]   rows_done;
  logic [PW-1:0] eff_w;
  logic [PW-1:0] remain;
  logic [3:0]    avail;
  logic [3:0]    npix;
  logic          row_start;
  logic          row_end;
  logic          area_done;
  logic          accept;

  // Row width with zero lifted to one and large values saturated
  always_comb begin
    if (cfg.row_width == 13'd0) begin
      eff_w = PW'(1);
    end else if (32'(cfg.row_width) > 32'(MAX_ROW_WIDTH)) begin
      eff_w = PW'(MAX_ROW_WIDTH);
    end else begin
      eff_w = PW'(cfg.row_width);
    end
  end

  // Classify the incoming byte
  always_comb begin
    row_start    = (pix_idx == '0);
    remain       = eff_w - pix_idx;
    avail        = row_start ? (BYTE_PIX - {1'b0, cfg.first_bit_offset}) : BYTE_PIX;
    row_end      = (32'(remain) <= 32'(avail));
    npix         = row_end ? 4'(remain) : avail;
    pix_idx_next = row_end ? '0 : (pix_idx + PW'(npix));
  end

  assign area_done = (rows_done >= cfg.row_count);
  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;
  assign q_push    = accept && !area_done;

  always_comb begin
    q_desc.data_byte = in_byte;
    q_desc.start_bit = row_start ? (BIT_MSB - cfg.first_bit_offset) : BIT_MSB;
    q_desc.npix      = npix;
    q_desc.row_start = row_start;
    q_desc.load_y    = (rows_done == 16'd0);
    q_desc.row_end   = row_end;
  end

  // Row position; bytes after the area is finished leave it untouched
  always_ff @(posedge clk) begin
    if (rst) begin
      pix_idx   <= '0;
      rows_done <= '0;
    end else if (q_push) begin
      pix_idx <= pix_idx_next;
      if (row_end) begin
        rows_done <= rows_done + 16'd1;
      end
    end
  end

endmodule

@@ sv/mbrs_queue.sv @@
// Short descriptor queue between front and back.
`timescale 1ns / 1ps

module mbrs_queue
  import mbrs_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  desc_t push_desc,
  output logic  full,
  input  logic  pop,
  output logic  head_valid,
  output desc_t head_desc
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  desc_t            slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_desc  = slots[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_desc;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

@@ sv/mbrs_back.sv @@
// Back end: walks a queued byte one pixel per cycle unless a held result stalls; closes runs, drives results.
`timescale 1ns / 1ps

module mbrs_back
  import mbrs_pkg::*;
#(
  parameter int MAX_ROW_WIDTH = MAX_ROW_WIDTH_DEF,
  parameter int COLOR_BITS    = COLOR_BITS_DEF,
  parameter int COORD_BITS    = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cfg_t                  cfg,
  input  logic [COLOR_BITS-1:0] zero_color,
  input  logic [COLOR_BITS-1:0] one_color,
  input  logic                  q_valid,
  input  desc_t                 q_desc,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [COORD_BITS-1:0] out_x,
  output logic [COORD_BITS-1:0] out_y,
  output logic [12:0]           out_len,
  output logic [COLOR_BITS-1:0] out_color,
  output logic                  out_last
);

  localparam int PW = $clog2(MAX_ROW_WIDTH + 1);

  // Run state
  logic [2:0]            step;
  logic [2:0]            step_next;
  logic                  flush;
  logic                  flush_next;
  logic                  cur_val;
  logic                  cur_val_next;
  logic [PW-1:0]         cur_run;
  logic [PW-1:0]         cur_run_next;
  logic [COORD_BITS-1:0] run_start;
  logic [COORD_BITS-1:0] run_start_next;
  logic [COORD_BITS-1:0] row_y;
  logic [COORD_BITS-1:0] row_y_next;

  // Held result, waiting to learn whether it is the last of its byte
  logic                  hv;
  logic                  h_last;
  logic [COORD_BITS-1:0] h_x;
  logic [COORD_BITS-1:0] h_y;
  logic [12:0]           h_len;
  logic [COLOR_BITS-1:0] h_color;

  // Step decode
  logic                  pix;
  logic                  first;
  logic                  last_bit;
  logic                  end_byte;
  logic                  emit;
  logic                  visible;
  logic                  step_go;
  logic                  out_free;
  logic                  push_out;
  logic [COORD_BITS-1:0] eff_start;
  logic [COORD_BITS-1:0] eff_y;
  logic [COORD_BITS-1:0] c_x;
  logic [COORD_BITS-1:0] c_y;

  assign pix      = q_desc.data_byte[q_desc.start_bit - step];
  assign first    = q_desc.row_start && (step == 3'd0) && !flush;
  assign last_bit = (step == 3'(q_desc.npix - 4'd1));
  assign end_byte = flush || (last_bit && !q_desc.row_end);

  assign eff_start = first ? COORD_BITS'(cfg.origin_x) : run_start;
  assign eff_y     = (first && q_desc.load_y) ? COORD_BITS'(cfg.origin_y) : row_y;

  // One pixel, or the row-end flush, per step
  always_comb begin
    emit           = 1'b0;
    c_x            = eff_start;
    c_y            = eff_y;
    cur_val_next   = cur_val;
    cur_run_next   = cur_run;
    run_start_next = eff_start;
    row_y_next     = eff_y;
    if (flush) begin
      emit         = 1'b1;
      cur_run_next = '0;
      row_y_next   = row_y + COORD_BITS'(1);
    end else if ((cur_run != '0) && (pix == cur_val)) begin
      cur_run_next = cur_run + PW'(1);
    end else begin
      emit         = (cur_run != '0);
      cur_val_next = pix;
      cur_run_next = PW'(1);
      if (cur_run != '0) begin
        run_start_next = eff_start + COORD_BITS'(cur_run);
      end
    end
  end

  assign visible  = emit && !cfg.transparent_mask[cur_val];
  assign out_free = !out_valid || out_ready;
  assign step_go  = q_valid && (!hv || out_free);
  assign q_pop    = step_go && end_byte;
  assign push_out = hv && out_free && (h_last || (step_go && visible));

  // Step counter within a byte
  always_comb begin
    step_next  = step;
    flush_next = flush;
    if (flush) begin
      step_next  = 3'd0;
      flush_next = 1'b0;
    end else if (last_bit) begin
      step_next  = 3'd0;
      flush_next = q_desc.row_end;
    end else begin
      step_next = step + 3'd1;
    end
  end

  // Run state and step control
  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= 3'd0;
      flush     <= 1'b0;
      cur_val   <= 1'b0;
      cur_run   <= '0;
      run_start <= COORD_BITS'(cfg.origin_x);
      row_y     <= COORD_BITS'(cfg.origin_y);
    end else if (step_go) begin
      step      <= step_next;
      flush     <= flush_next;
      cur_val   <= cur_val_next;
      cur_run   <= cur_run_next;
      run_start <= run_start_next;
      row_y     <= row_y_next;
    end
  end

  // Hold stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      hv     <= 1'b0;
      h_last <= 1'b0;
    end else begin
      if (step_go && visible) begin
        hv     <= 1'b1;
        h_last <= end_byte;
      end else begin
        if (push_out) begin
          hv <= 1'b0;
        end else if (step_go && end_byte && hv) begin
          h_last <= 1'b1;
        end
      end
    end
  end

  // Hold stage payload
  always_ff @(posedge clk) begin
    if (step_go && visible) begin
      h_x     <= c_x;
      h_y     <= c_y;
      h_len   <= 13'(cur_run);
      h_color <= cur_val ? one_color : zero_color;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_out) begin
      out_x     <= h_x;
      out_y     <= h_y;
      out_len   <= h_len;
      out_color <= h_color;
      out_last  <= h_last;
    end
  end

endmodule

@@ sv/mono_bitmap_row_run_splitter.sv @@
// Top level: register port, front end, descriptor queue and run back end.
// Throughput: the back end steps through a byte one pixel at a time, plus a flush step at row end;
//   one result per cycle at most.
// A result passes from the queue through the back-end step, the hold stage and the output
//   register to m_tdata, and also waits for the pixels walked before its run closes.
// Reset (rst, synchronous): row and run state cleared, queue emptied, registers to defaults.
`timescale 1ns / 1ps

module mono_bitmap_row_run_splitter
  import mbrs_pkg::*;
#(
  parameter int MAX_ROW_WIDTH = MAX_ROW_WIDTH_DEF,
  parameter int COLOR_BITS    = COLOR_BITS_DEF,
  parameter int COORD_BITS    = COORD_BITS_DEF,
  parameter int OUT_W         = ((2 * COORD_BITS + 13 + COLOR_BITS + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  // APB register port
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [4:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // Byte stream in
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [7:0]       s_tdata,   // data_byte
  // Run stream out
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,   // run_x, run_y, run_length, run_color, zero pad
  output logic             m_tlast
);

  cfg_t                  cfg;
  logic [COLOR_BITS-1:0] zero_color;
  logic [COLOR_BITS-1:0] one_color;
  logic                  wr_en;
  reg_idx_t              reg_idx;

  logic                  q_push;
  logic                  q_full;
  logic                  q_pop;
  logic                  q_valid;
  desc_t                 push_desc;
  desc_t                 head_desc;

  logic [COORD_BITS-1:0] run_x;
  logic [COORD_BITS-1:0] run_y;
  logic [12:0]           run_length;
  logic [COLOR_BITS-1:0] run_color;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[4:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin_x         <= '0;
      cfg.origin_y         <= '0;
      cfg.row_width        <= 13'd1;
      cfg.row_count        <= 16'd1;
      cfg.first_bit_offset <= '0;
      cfg.transparent_mask <= '0;
      zero_color           <= '0;
      one_color            <= COLOR_BITS'(1);
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_ORIGIN_X:     cfg.origin_x         <= pwdata[15:0];
        REG_ORIGIN_Y:     cfg.origin_y         <= pwdata[15:0];
        REG_ROW_WIDTH:    cfg.row_width        <= pwdata[12:0];
        REG_ROW_COUNT:    cfg.row_count        <= pwdata[15:0];
        REG_FIRST_OFFSET: cfg.first_bit_offset <= pwdata[2:0];
        REG_ZERO_COLOR:   zero_color           <= COLOR_BITS'(pwdata);
        REG_ONE_COLOR:    one_color            <= COLOR_BITS'(pwdata);
        REG_TRANSP_MASK:  cfg.transparent_mask <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  // Register read back
  always_comb begin
    unique case (reg_idx)
      REG_ORIGIN_X:     prdata = 32'(cfg.origin_x);
      REG_ORIGIN_Y:     prdata = 32'(cfg.origin_y);
      REG_ROW_WIDTH:    prdata = 32'(cfg.row_width);
      REG_ROW_COUNT:    prdata = 32'(cfg.row_count);
      REG_FIRST_OFFSET: prdata = 32'(cfg.first_bit_offset);
      REG_ZERO_COLOR:   prdata = 32'(zero_color);
      REG_ONE_COLOR:    prdata = 32'(one_color);
      REG_TRANSP_MASK:  prdata = 32'(cfg.transparent_mask);
      default:          prdata = '0;
    endcase
  end

  mbrs_front #(
    .MAX_ROW_WIDTH(MAX_ROW_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_byte  (s_tdata),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_desc   (push_desc)
  );

  mbrs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_desc  (push_desc),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_desc  (head_desc)
  );

  mbrs_back #(
    .MAX_ROW_WIDTH(MAX_ROW_WIDTH),
    .COLOR_BITS   (COLOR_BITS),
    .COORD_BITS   (COORD_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .zero_color (zero_color),
    .one_color  (one_color),
    .q_valid    (q_valid),
    .q_desc     (head_desc),
    .q_pop      (q_pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_x      (run_x),
    .out_y      (run_y),
    .out_len    (run_length),
    .out_color  (run_color),
    .out_last   (m_tlast)
  );

  // Pack result fields, first field lowest
  assign m_tdata = OUT_W'({run_color, run_length, run_y, run_x});

endmodule

@@ sv/mbrs_checker.sv @@
// Port-level checks for the run splitter, bound to the top level.
`timescale 1ns / 1ps

module mbrs_checker #(
  parameter int COORD_BITS = 16,
  parameter int OUT_W      = 80
) (
  input logic             clk,
  input logic             rst,
  input logic             psel,
  input logic             penable,
  input logic             pwrite,
  input logic [4:0]       paddr,
  input logic [31:0]      pwdata,
  input logic [31:0]      prdata,
  input logic             s_tready,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata,
  input logic             m_tlast
);

  localparam int LEN_LO = 2 * COORD_BITS;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("stalled result changed");

  // Every run covers at least one pixel
  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[LEN_LO +: 13] != 13'd0))
    else $error("zero-length run");

  // Reset leaves no result pending and the input side open
  a_reset_state: assert property (@(posedge clk)
    rst |=> (!m_tvalid && s_tready))
    else $error("bad state after reset");

  // A written origin_x reads back while the address is held
  a_readback: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && (paddr == 5'd0))
      |=> ((paddr != $past(paddr)) || (prdata[15:0] == $past(pwdata[15:0]))))
    else $error("register read back mismatch");

endmodule

bind mono_bitmap_row_run_splitter mbrs_checker #(
  .COORD_BITS(COORD_BITS),
  .OUT_W     (OUT_W)
) u_mbrs_checker (
  .clk      (clk),
  .rst      (rst),
  .psel     (psel),
  .penable  (penable),
  .pwrite   (pwrite),
  .paddr    (paddr),
  .pwdata   (pwdata),
  .prdata   (prdata),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

@@ test/mbrs_run_checker.sv @@
// Checker for the bitmap row run splitter: predicts run rectangles and compares them.
`timescale 1ns / 1ps

module mbrs_run_checker
  import mbrs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [79:0] m_tdata,   // run_x, run_y, run_length, run_color, zero pad
  input  logic        m_tlast,
  output int          errors,
  output int          pending
);

  // One run rectangle as it leaves the block
  typedef struct packed {
    logic [15:0] run_x;
    logic [15:0] run_y;
    logic [12:0] run_len;
    logic [31:0] run_color;
    logic        last;
  } run_t;

  // Register copies
  logic [15:0] org_x, org_y;
  logic [12:0] width_reg;
  logic [15:0] count_reg;
  logic [2:0]  offset_reg;
  logic [31:0] zero_col, one_col;
  logic [1:0]  hide_mask;

  // Row and run state
  int unsigned pix_idx;
  bit          cur_val;
  int unsigned cur_run;
  logic [15:0] run_x0;
  logic [15:0] row_y;
  logic [15:0] rows_done;

  run_t runs_due [$];
  run_t batch [$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
    case (idx)
      REG_ORIGIN_X:     org_x      = val[15:0];
      REG_ORIGIN_Y:     org_y      = val[15:0];
      REG_ROW_WIDTH:    width_reg  = val[12:0];
      REG_ROW_COUNT:    count_reg  = val[15:0];
      REG_FIRST_OFFSET: offset_reg = val[2:0];
      REG_ZERO_COLOR:   zero_col   = val;
      REG_ONE_COLOR:    one_col    = val;
      REG_TRANSP_MASK:  hide_mask  = val[1:0];
      default: ;
    endcase
  endtask

  // Close the open run, unless its bit value is hidden
  task automatic close_run();
    run_t r;
    if (!hide_mask[cur_val]) begin
      r.run_x     = run_x0;
      r.run_y     = row_y;
      r.run_len   = 13'(cur_run);
      r.run_color = cur_val ? one_col : zero_col;
      r.last      = 1'b0;
      batch.push_back(r);
    end
  endtask

  // Walk the pixels of one byte and queue the runs it closes
  task automatic predict_runs(input logic [7:0] b);
    int          bitpos;
    int unsigned w;
    bit          v;
    run_t        r;
    batch.delete();
    if (width_reg == 0) w = 1;
    else if (width_reg > MAX_ROW_WIDTH_DEF) w = MAX_ROW_WIDTH_DEF;
    else w = width_reg;
    if (rows_done >= count_reg) return;

    if (pix_idx == 0) begin
      run_x0 = org_x;
      if (rows_done == 0) row_y = org_y;
      cur_run = 0;
      bitpos  = int'(BIT_MSB) - int'(offset_reg);
    end else begin
      bitpos = int'(BIT_MSB);
    end

    while (bitpos >= 0 && pix_idx < w) begin
      v = b[bitpos];
      if (cur_run != 0 && v == cur_val) begin
        cur_run++;
      end else begin
        if (cur_run != 0) begin
          close_run();
          run_x0 = run_x0 + 16'(cur_run);
        end
        cur_val = v;
        cur_run = 1;
      end
      pix_idx++;
      bitpos--;
    end

    // Row end: rest of the byte is dropped
    if (pix_idx >= w) begin
      close_run();
      pix_idx   = 0;
      cur_run   = 0;
      row_y     = row_y + 16'd1;
      rows_done = rows_done + 16'd1;
    end

    foreach (batch[i]) begin
      r      = batch[i];
      r.last = (i == batch.size() - 1);
      runs_due.push_back(r);
    end
  endtask

  // Watch register writes, accepted bytes and accepted runs
  always @(posedge clk) begin
    run_t want;
    run_t got;
    if (rst) begin
      org_x      = '0;
      org_y      = '0;
      width_reg  = 13'd1;
      count_reg  = 16'd1;
      offset_reg = '0;
      zero_col   = '0;
      one_col    = 32'd1;
      hide_mask  = '0;
      pix_idx    = 0;
      cur_val    = 1'b0;
      cur_run    = 0;
      run_x0     = '0;
      row_y      = '0;
      rows_done  = '0;
      runs_due.delete();
    end else begin
      if (psel && penable && pwrite && pready)
        write_reg(reg_idx_t'(paddr[4:2]), pwdata);
      if (s_tvalid && s_tready)
        predict_runs(s_tdata);
      if (m_tvalid && m_tready) begin
        got.run_x     = m_tdata[15:0];
        got.run_y     = m_tdata[31:16];
        got.run_len   = m_tdata[44:32];
        got.run_color = m_tdata[76:45];
        got.last      = m_tlast;
        if (runs_due.size() == 0) begin
          errors++;
          $display("%0t: run transaction with none outstanding: x=%h y=%h len=%0d colour=%h last=%b",
                   $time, got.run_x, got.run_y, got.run_len, got.run_color, got.last);
        end else begin
          want = runs_due.pop_front();
          if (got !== want) begin
            errors++;
            $display("%0t: run mismatch, expected x=%h y=%h len=%0d colour=%h last=%b",
                     $time, want.run_x, want.run_y, want.run_len, want.run_color, want.last);
            $display("%0t:                   got x=%h y=%h len=%0d colour=%h last=%b",
                     $time, got.run_x, got.run_y, got.run_len, got.run_color, got.last);
          end
        end
      end
    end
    pending = runs_due.size();
  end

endmodule

@@ test/testbench.sv @@
// Testbench top: clock, reset, register and byte stimulus, and the final verdict.
`timescale 1ns / 1ps

module testbench;
  import mbrs_pkg::*;

  localparam int LIMIT = 800000;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [4:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;
  logic        m_tlast;

  int errors;
  int pending;
  int cycles  = 0;
  bit idle_on = 1'b1;

  // Row geometry as last written, for framing whole rows
  int cur_w   = 1;
  int cur_off = 0;

  mono_bitmap_row_run_splitter u_dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  mbrs_run_checker u_checker (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .errors   (errors),
    .pending  (pending)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Run guard
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Run receiver back-pressure
  always @(negedge clk)
    m_tready <= !(idle_on && $urandom_range(99) < 35);

  task automatic cfg_write(input reg_idx_t idx, input logic [31:0] val);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = val;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_area(input logic [15:0] ox, input logic [15:0] oy,
                          input logic [12:0] w, input logic [15:0] cnt,
                          input logic [2:0] off, input logic [31:0] zc,
                          input logic [31:0] oc, input logic [1:0] mask);
    cfg_write(REG_ORIGIN_X, {16'd0, ox});
    cfg_write(REG_ORIGIN_Y, {16'd0, oy});
    cfg_write(REG_ROW_WIDTH, {19'd0, w});
    cfg_write(REG_ROW_COUNT, {16'd0, cnt});
    cfg_write(REG_FIRST_OFFSET, {29'd0, off});
    cfg_write(REG_ZERO_COLOR, zc);
    cfg_write(REG_ONE_COLOR, oc);
    cfg_write(REG_TRANSP_MASK, {30'd0, mask});
    if (w == 0) cur_w = 1;
    else if (w > MAX_ROW_WIDTH_DEF) cur_w = MAX_ROW_WIDTH_DEF;
    else cur_w = w;
    cur_off = off;
  endtask

  // One byte transaction; tvalid stays high afterwards until the next call decides
  task automatic push_byte(input logic [7:0] b);
    @(negedge clk);
    while (idle_on && $urandom_range(99) < 35) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Stop sending and wait until every run has come out and the block has settled
  task automatic drain_runs();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (64) @(posedge clk);
  endtask

  // Mix of random bytes, solid bytes and alternating bytes
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(9))
      5:       return 8'h00;
      6:       return 8'hFF;
      7:       return 8'h55;
      8:       return 8'hAA;
      9:       return {4{$urandom_range(1) == 1 ? 2'b11 : 2'b00}};
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic send_rows(input int nrows, output int sent);
    int per_row;
    per_row = (cur_off + cur_w + 7) / 8;
    sent    = 0;
    repeat (nrows) begin
      repeat (per_row) begin
        push_byte(pick_byte());
        sent++;
      end
    end
  endtask

  initial begin
    int          rand_bytes;
    int          phase;
    int          sent;
    int          sel;
    logic [12:0] w;
    logic [15:0] ox;
    logic [1:0]  mask;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Near-wrap origin, offset in mid-byte, two rows of twenty pixels
    set_area(16'hFFF0, 16'hFFFF, 13'd20, 16'hFFFF, 3'd3, 32'h0, 32'hFFFF_FFFF, 2'd0);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'hAA);
    push_byte(8'h55);
    // hold off mid-row until every run has come out
    drain_runs();
    push_byte(8'hAA);
    push_byte(8'h55);
    drain_runs();

    // Single-pixel rows taken from the last bit
    set_area(16'h0000, 16'h0000, 13'd1, 16'hFFFF, 3'd7, 32'h1234_5678, 32'h8765_4321, 2'd0);
    push_byte(8'h01);
    push_byte(8'h00);
    push_byte(8'hFE);
    drain_runs();

    // Zero runs hidden; a blank byte gives nothing
    set_area(16'h0100, 16'h0000, 13'd8, 16'hFFFF, 3'd0, 32'hAAAA_AAAA, 32'h5555_5555, 2'd1);
    push_byte(8'h0F);
    push_byte(8'hF0);
    push_byte(8'h00);
    push_byte(8'hFF);
    drain_runs();

    // One runs hidden, then both
    set_area(16'h0100, 16'h0000, 13'd8, 16'hFFFF, 3'd0, 32'hAAAA_AAAA, 32'h5555_5555, 2'd2);
    push_byte(8'hAA);
    drain_runs();
    set_area(16'h0100, 16'h0000, 13'd8, 16'hFFFF, 3'd0, 32'hAAAA_AAAA, 32'h5555_5555, 2'd3);
    push_byte(8'h5A);
    drain_runs();

    // Zero width behaves as one pixel
    set_area(16'h8000, 16'h0000, 13'd0, 16'hFFFF, 3'd0, 32'hDEAD_BEEF, 32'h0000_0001, 2'd0);
    push_byte(8'h80);
    push_byte(8'h7F);
    drain_runs();

    // Runs that span byte boundaries
    set_area(16'h0010, 16'h0000, 13'd16, 16'hFFFF, 3'd0, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 2'd0);
    push_byte(8'h00);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'hFF);
    drain_runs();

    // Random areas of whole rows
    rand_bytes = 0;
    phase      = 0;
    while (rand_bytes < 200) begin
      idle_on = !(phase >= 3 && phase < 7);
      sel = $urandom_range(99);
      if (sel < 5) w = 13'd0;
      else if (sel < 10) w = 13'd1;
      else if (sel < 20) w = 13'($urandom_range(49, 120));
      else w = 13'($urandom_range(2, 48));
      case ($urandom_range(3))
        0:       ox = 16'h0000;
        1:       ox = 16'hFFFF;
        default: ox = 16'($urandom_range(65535));
      endcase
      sel  = $urandom_range(5);
      mask = (sel > 3) ? 2'd0 : 2'(sel);
      set_area(ox, 16'($urandom_range(65535)), w, 16'hFFFF, 3'($urandom_range(7)),
               $urandom, $urandom, mask);
      send_rows($urandom_range(1, 4), sent);
      rand_bytes += sent;
      drain_runs();
      phase++;
    end
    idle_on = 1'b1;

    // Widest rows: exact maximum, and a width that saturates
    set_area(16'hF000, 16'h0000, 13'd4096, 16'hFFFF, 3'd7, $urandom, $urandom, 2'd0);
    send_rows(1, sent);
    drain_runs();
    set_area(16'h0000, 16'h0000, 13'd8191, 16'hFFFF, 3'd0, $urandom, $urandom, 2'd0);
    send_rows(1, sent);
    drain_runs();

    // Area finished: bytes are swallowed without any run
    set_area(16'h0000, 16'h0000, 13'd8, 16'd1, 3'd0, 32'h1, 32'h2, 2'd0);
    repeat (3) push_byte(pick_byte());
    drain_runs();
    set_area(16'h0000, 16'h0000, 13'd8, 16'd0, 3'd0, 32'h1, 32'h2, 2'd0);
    repeat (3) push_byte(pick_byte());
    drain_runs();

    if (errors == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
